### hw/rtl/sdpf_pkg.sv
// ----------------------------------------------------------------------------
// sdpf_pkg
// Shared types and constants for the spring-damper pose follower.
// ----------------------------------------------------------------------------
`default_nettype none

package sdpf_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned NumAxes  = 6;
  localparam int unsigned AxisW    = 3;
  localparam int unsigned CntW     = 6;
  localparam int unsigned SqSteps  = 4;   // three squares, one trailing add
  localparam int unsigned SqrtSteps = 34; // root bits
  localparam int unsigned DivSteps = 32;  // quotient bits

  localparam logic [15:0] SpringGainRst   = 16'd6554;
  localparam logic [15:0] FrictionGainRst = 16'd6554;
  localparam logic [30:0] RefDistRst      = 31'd655360;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SPRING   = 2'd0,
    CFG_FRICTION = 2'd1,
    CFG_REF_DIST = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [CoordW-1:0] eye_x;
    logic signed [CoordW-1:0] eye_y;
    logic signed [CoordW-1:0] eye_z;
    logic signed [CoordW-1:0] aim_x;
    logic signed [CoordW-1:0] aim_y;
    logic signed [CoordW-1:0] aim_z;
    logic                     restart;
  } in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] smooth_eye_x;
    logic signed [CoordW-1:0] smooth_eye_y;
    logic signed [CoordW-1:0] smooth_eye_z;
    logic signed [CoordW-1:0] smooth_aim_x;
    logic signed [CoordW-1:0] smooth_aim_y;
    logic signed [CoordW-1:0] smooth_aim_z;
  } out_t;

  typedef struct packed {
    logic             load;
    logic             snap;
    logic             sq_mul;
    logic             sq_acc;
    logic             sqrt_init;
    logic             sqrt_step;
    logic             div_init;
    logic             div_step;
    logic             ax_mul;
    logic             ax_vel;
    logic             ax_dmp;
    logic             ax_upd;
    logic             out_load;
    logic [AxisW-1:0] idx;
  } ctrl_t;

  typedef enum logic [10:0] {
    S_IDLE      = 11'b000_0000_0001,
    S_SQ        = 11'b000_0000_0010,
    S_SQRT_INIT = 11'b000_0000_0100,
    S_SQRT      = 11'b000_0000_1000,
    S_DIV_INIT  = 11'b000_0001_0000,
    S_DIV       = 11'b000_0010_0000,
    S_AX_MUL    = 11'b000_0100_0000,
    S_AX_VEL    = 11'b000_1000_0000,
    S_AX_DMP    = 11'b001_0000_0000,
    S_AX_UPD    = 11'b010_0000_0000,
    S_DONE      = 11'b100_0000_0000
  } state_e;

endpackage

`default_nettype wire

### hw/rtl/sdpf_ctrl.sv
// ----------------------------------------------------------------------------
// sdpf_ctrl
// Sequencer: steps the datapath through squares, root, divide and axes.
// ----------------------------------------------------------------------------
`default_nettype none

module sdpf_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic           in_restart_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output sdpf_pkg::ctrl_t     ctrl_o
);

  sdpf_pkg::state_e                 state_q, state_d;
  logic [sdpf_pkg::CntW-1:0]        cnt_q, cnt_d;
  logic                             first_q, first_d;
  logic                             out_valid_q, out_valid_d;
  logic                             accept;

  assign in_stall_o  = (state_q != sdpf_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && (state_q == sdpf_pkg::S_IDLE);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    first_d     = first_q;
    out_valid_d = out_valid_q && out_stall_i;
    ctrl_o      = '0;
    ctrl_o.idx  = cnt_q[sdpf_pkg::AxisW-1:0];
    unique case (state_q)
      sdpf_pkg::S_IDLE: begin
        if (accept) begin
          ctrl_o.load = 1'b1;
          ctrl_o.snap = first_q || in_restart_i;
          first_d     = 1'b0;
          cnt_d       = '0;
          state_d     = (first_q || in_restart_i) ? sdpf_pkg::S_DONE : sdpf_pkg::S_SQ;
        end
      end
      sdpf_pkg::S_SQ: begin
        ctrl_o.sq_mul = (cnt_q != sdpf_pkg::CntW'(sdpf_pkg::SqSteps - 1));
        ctrl_o.sq_acc = (cnt_q != '0);
        if (cnt_q == sdpf_pkg::CntW'(sdpf_pkg::SqSteps - 1)) begin
          cnt_d   = '0;
          state_d = sdpf_pkg::S_SQRT_INIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      sdpf_pkg::S_SQRT_INIT: begin
        ctrl_o.sqrt_init = 1'b1;
        state_d          = sdpf_pkg::S_SQRT;
      end
      sdpf_pkg::S_SQRT: begin
        ctrl_o.sqrt_step = 1'b1;
        if (cnt_q == sdpf_pkg::CntW'(sdpf_pkg::SqrtSteps - 1)) begin
          cnt_d   = '0;
          state_d = sdpf_pkg::S_DIV_INIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      sdpf_pkg::S_DIV_INIT: begin
        ctrl_o.div_init = 1'b1;
        state_d         = sdpf_pkg::S_DIV;
      end
      sdpf_pkg::S_DIV: begin
        ctrl_o.div_step = 1'b1;
        if (cnt_q == sdpf_pkg::CntW'(sdpf_pkg::DivSteps - 1)) begin
          cnt_d   = '0;
          state_d = sdpf_pkg::S_AX_MUL;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      sdpf_pkg::S_AX_MUL: begin
        ctrl_o.ax_mul = 1'b1;
        state_d       = sdpf_pkg::S_AX_VEL;
      end
      sdpf_pkg::S_AX_VEL: begin
        ctrl_o.ax_vel = 1'b1;
        state_d       = sdpf_pkg::S_AX_DMP;
      end
      sdpf_pkg::S_AX_DMP: begin
        ctrl_o.ax_dmp = 1'b1;
        state_d       = sdpf_pkg::S_AX_UPD;
      end
      sdpf_pkg::S_AX_UPD: begin
        ctrl_o.ax_upd = 1'b1;
        if (cnt_q == sdpf_pkg::CntW'(sdpf_pkg::NumAxes - 1)) begin
          cnt_d   = '0;
          state_d = sdpf_pkg::S_DONE;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = sdpf_pkg::S_AX_MUL;
        end
      end
      sdpf_pkg::S_DONE: begin
        // hand over once the output register is free
        if (!out_valid_q || !out_stall_i) begin
          ctrl_o.out_load = 1'b1;
          out_valid_d     = 1'b1;
          state_d         = sdpf_pkg::S_IDLE;
        end
      end
      default: state_d = sdpf_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sdpf_pkg::S_IDLE;
      cnt_q       <= '0;
      first_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sdpf_datapath.sv
// ----------------------------------------------------------------------------
// sdpf_datapath
// Shared multiplier, bit-serial root and divider, per-axis spring update.
// ----------------------------------------------------------------------------
`default_nettype none

module sdpf_datapath (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire sdpf_pkg::ctrl_t  ctrl_i,
  input  wire sdpf_pkg::in_t    in_i,
  input  wire logic [15:0]      spring_gain_i,
  input  wire logic [15:0]      friction_gain_i,
  input  wire logic [30:0]      ref_dist_i,
  output sdpf_pkg::out_t        out_o
);

  logic signed [31:0] in_arr [sdpf_pkg::NumAxes];
  logic signed [31:0] cmd_q  [sdpf_pkg::NumAxes];
  logic signed [31:0] pos_q  [sdpf_pkg::NumAxes];
  logic signed [31:0] vel_q  [sdpf_pkg::NumAxes];

  logic [46:0] n_q;
  logic [65:0] acc_q;
  logic [65:0] prod_q, prod_d;
  logic [67:0] s_q;
  logic [34:0] rem_q;
  logic [33:0] root_q;
  logic [33:0] drem_q;
  logic [31:0] quo_q;
  logic        dzero_q, dovf_q;
  logic        esign_q;
  logic signed [31:0] v_q;
  sdpf_pkg::out_t out_q;

  logic [sdpf_pkg::AxisW-1:0] a, b;
  logic signed [32:0] d, err;
  logic [32:0] dmag, emag;
  logic [31:0] vmag, g;
  logic [32:0] mul_a, mul_b;
  logic [36:0] rem_t, trial;
  logic        sq_ge;
  logic [34:0] div_t;
  logic        div_ge;
  logic [48:0] inc;
  logic signed [50:0] vs;
  logic signed [31:0] vsat;
  logic [30:0] damp;
  logic signed [31:0] v2;
  logic signed [32:0] ps;
  logic signed [31:0] psat;

  assign in_arr[0] = in_i.eye_x;
  assign in_arr[1] = in_i.eye_y;
  assign in_arr[2] = in_i.eye_z;
  assign in_arr[3] = in_i.aim_x;
  assign in_arr[4] = in_i.aim_y;
  assign in_arr[5] = in_i.aim_z;

  assign a = ctrl_i.idx;
  assign b = ctrl_i.idx + 3'd3;  // matching aim axis for the distance

  assign d    = {cmd_q[a][31], cmd_q[a]} - {cmd_q[b][31], cmd_q[b]};
  assign dmag = d[32] ? 33'(-d) : 33'(d);
  assign err  = {cmd_q[a][31], cmd_q[a]} - {pos_q[a][31], pos_q[a]};
  assign emag = err[32] ? 33'(-err) : 33'(err);
  assign vmag = v_q[31] ? 32'(-v_q) : 32'(v_q);

  // spring gain: zero without a distance, clipped when the quotient overflows
  assign g = dzero_q ? 32'd0 : (dovf_q ? 32'hFFFF_FFFF : quo_q);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (ctrl_i.sq_mul) begin
      mul_a = dmag;
      mul_b = dmag;
    end else if (ctrl_i.ax_mul) begin
      mul_a = emag;
      mul_b = {1'b0, g};
    end else if (ctrl_i.ax_dmp) begin
      mul_a = {1'b0, vmag};
      mul_b = {17'd0, friction_gain_i};
    end
  end
  assign prod_d = mul_a * mul_b;

  // one root bit per step
  assign rem_t = {rem_q, s_q[67:66]};
  assign trial = {1'b0, root_q, 2'b01};
  assign sq_ge = (rem_t >= trial);

  // one quotient bit per step
  assign div_t  = {drem_q, quo_q[31]};
  assign div_ge = (div_t >= {1'b0, root_q});

  assign inc  = prod_q[64:16];
  assign vs   = esign_q ? ({{19{vel_q[a][31]}}, vel_q[a]} - {2'b00, inc})
                        : ({{19{vel_q[a][31]}}, vel_q[a]} + {2'b00, inc});
  assign vsat = (vs[50:31] == {20{vs[50]}}) ? vs[31:0]
              : (vs[50] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

  assign damp = prod_q[46:16];
  assign v2   = v_q[31] ? (v_q + $signed({1'b0, damp})) : (v_q - $signed({1'b0, damp}));
  assign ps   = {pos_q[a][31], pos_q[a]} + {v2[31], v2};
  assign psat = (ps[32] == ps[31]) ? ps[31:0]
              : (ps[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < sdpf_pkg::NumAxes; i++) begin
        pos_q[i] <= '0;
        vel_q[i] <= '0;
      end
    end else if (ctrl_i.load && ctrl_i.snap) begin
      for (int i = 0; i < sdpf_pkg::NumAxes; i++) begin
        pos_q[i] <= in_arr[i];
        vel_q[i] <= '0;
      end
    end else if (ctrl_i.ax_upd) begin
      vel_q[a] <= v2;
      pos_q[a] <= psat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      for (int i = 0; i < sdpf_pkg::NumAxes; i++) begin
        cmd_q[i] <= in_arr[i];
      end
      n_q   <= spring_gain_i * ref_dist_i;
      acc_q <= '0;
    end else if (ctrl_i.sq_acc) begin
      acc_q <= acc_q + prod_q;
    end

    if (ctrl_i.sq_mul || ctrl_i.ax_mul || ctrl_i.ax_dmp) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.ax_mul) begin
      esign_q <= err[32];
    end
    if (ctrl_i.ax_vel) begin
      v_q <= vsat;
    end

    if (ctrl_i.sqrt_init) begin
      s_q    <= {2'b00, acc_q};
      rem_q  <= '0;
      root_q <= '0;
    end else if (ctrl_i.sqrt_step) begin
      s_q    <= {s_q[65:0], 2'b00};
      rem_q  <= sq_ge ? 35'(rem_t - trial) : 35'(rem_t);
      root_q <= {root_q[32:0], sq_ge};
    end

    if (ctrl_i.div_init) begin
      dzero_q <= (root_q == '0);
      dovf_q  <= ({19'd0, n_q[46:32]} >= root_q);
      drem_q  <= {19'd0, n_q[46:32]};
      quo_q   <= n_q[31:0];
    end else if (ctrl_i.div_step) begin
      drem_q <= div_ge ? 34'(div_t - {1'b0, root_q}) : 34'(div_t);
      quo_q  <= {quo_q[30:0], div_ge};
    end

    if (ctrl_i.out_load) begin
      out_q.smooth_eye_x <= pos_q[0];
      out_q.smooth_eye_y <= pos_q[1];
      out_q.smooth_eye_z <= pos_q[2];
      out_q.smooth_aim_x <= pos_q[3];
      out_q.smooth_aim_y <= pos_q[4];
      out_q.smooth_aim_z <= pos_q[5];
    end
  end

  assign out_o = out_q;

endmodule

`default_nettype wire

### hw/rtl/spring_damper_pose_follower.sv
// ----------------------------------------------------------------------------
// spring_damper_pose_follower
// Smooths a commanded eye and aim point toward their commands with a
// damped spring whose gain scales with reference over current distance.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            payload
//   in        in         in_valid_i/in_stall_o   in_i  (sdpf_pkg::in_t)
//   out       out        out_valid_o/out_stall_i out_o (sdpf_pkg::out_t)
//   cfg       in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// An ordinary item, after its transfer, runs through the squared distance
// on the shared multiplier, the bit-serial square root, the bit-serial gain
// divide and the spring updates of the six axes, then loads the output
// register. A snap item (first after reset or restart set) skips the
// arithmetic and loads the output register. Reset clears the sequencer,
// the positions, the velocities and loads the default gains. A stalled
// result holds in the output register; the next input may still transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module spring_damper_pose_follower (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire sdpf_pkg::in_t                      in_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output sdpf_pkg::out_t                          out_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [sdpf_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire logic [sdpf_pkg::CfgDataW-1:0]      cfg_data_i
);

  logic [15:0] spring_gain_q;
  logic [15:0] friction_gain_q;
  logic [30:0] ref_dist_q;
  sdpf_pkg::ctrl_t ctrl;

  // config is always accepted; only written while idle by contract
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spring_gain_q   <= sdpf_pkg::SpringGainRst;
      friction_gain_q <= sdpf_pkg::FrictionGainRst;
      ref_dist_q      <= sdpf_pkg::RefDistRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sdpf_pkg::CFG_SPRING:   spring_gain_q   <= cfg_data_i[15:0];
        sdpf_pkg::CFG_FRICTION: friction_gain_q <= cfg_data_i[15:0];
        sdpf_pkg::CFG_REF_DIST: ref_dist_q      <= cfg_data_i[30:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  sdpf_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_restart_i (in_i.restart),
    .in_stall_o   (in_stall_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .ctrl_o       (ctrl)
  );

  sdpf_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .in_i            (in_i),
    .spring_gain_i   (spring_gain_q),
    .friction_gain_i (friction_gain_q),
    .ref_dist_i      (ref_dist_q),
    .out_o           (out_o)
  );

endmodule

`default_nettype wire

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the spring-damper pose follower. An in-bench
// fixed-point predictor tracks the smoothed eye and aim points. Directed
// items, config sweeps and random follow trajectories run with random idle
// cycles on both sides, and every result transfer is checked field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  // Index past the register file; writes to it must be dropped.
  localparam logic [sdpf_pkg::CfgIdxW-1:0] CfgUnused = 2'd3;
  localparam longint SatMax = 64'sd2147483647;
  localparam longint SatMin = -64'sd2147483648;
  localparam int DrainLimit = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  sdpf_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sdpf_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [sdpf_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [sdpf_pkg::CfgDataW-1:0] cfg_data = '0;

  always #5 clk = ~clk;

  spring_damper_pose_follower dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_i       (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_o      (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  // Predictor state: index 0..2 is the eye point, 3..5 the aim point.
  longint pose_pos[6];
  longint pose_vel[6];
  bit     snap_pending;
  longint unsigned spring_gain, friction_gain, ref_dist;

  sdpf_pkg::out_t pose_queue[$];
  int   mismatches = 0;
  bit   quiet = 1'b0;   // no idling on either side while set

  function automatic longint sat32(longint x);
    if (x > SatMax) return SatMax;
    if (x < SatMin) return SatMin;
    return x;
  endfunction

  function automatic longint unsigned magnitude(longint x);
    return (x < 0) ? longint'(-x) : x;
  endfunction

  // Bit-serial floor square root of a sum of up to three 66-bit squares.
  function automatic longint unsigned root_of(logic [69:0] s);
    logic [69:0] r, c;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      c = r | (70'd1 << b);
      if (c * c <= s) r = c;
    end
    return r[63:0];
  endfunction

  // One axis of the spring update; both factors fit in 32 bits, so the 64-bit product cannot wrap.
  function automatic void spring_axis(int a, longint cmd, longint unsigned g);
    longint err, v;
    longint unsigned inc, damp;
    err = cmd - pose_pos[a];
    inc = (magnitude(err) * g) >> 16;
    v = pose_vel[a] + ((err < 0) ? -longint'(inc) : longint'(inc));
    v = sat32(v);
    damp = (magnitude(v) * friction_gain) >> 16;
    v = (v < 0) ? v + longint'(damp) : v - longint'(damp);
    pose_vel[a] = v;
    pose_pos[a] = sat32(pose_pos[a] + v);
  endfunction

  function automatic sdpf_pkg::out_t follow_pose(sdpf_pkg::in_t it);
    longint cmd[6];
    logic [69:0] sum;
    longint unsigned d, span, g;
    sdpf_pkg::out_t r;
    cmd[0] = it.eye_x; cmd[1] = it.eye_y; cmd[2] = it.eye_z;
    cmd[3] = it.aim_x; cmd[4] = it.aim_y; cmd[5] = it.aim_z;
    if (snap_pending || it.restart) begin
      snap_pending = 1'b0;
      for (int a = 0; a < 6; a++) begin
        pose_pos[a] = cmd[a];
        pose_vel[a] = 0;
      end
    end else begin
      sum = '0;
      for (int a = 0; a < 3; a++) begin
        d = magnitude(cmd[a] - cmd[a+3]);
        sum += 70'(d) * 70'(d);
      end
      span = root_of(sum);
      g = 0;
      // zero commanded distance drops the spring term
      if (span != 0) begin
        g = (spring_gain * ref_dist) / span;
        if (g > 64'hFFFF_FFFF) g = 64'hFFFF_FFFF;
      end
      for (int a = 0; a < 6; a++) spring_axis(a, cmd[a], g);
    end
    r.smooth_eye_x = pose_pos[0][31:0];
    r.smooth_eye_y = pose_pos[1][31:0];
    r.smooth_eye_z = pose_pos[2][31:0];
    r.smooth_aim_x = pose_pos[3][31:0];
    r.smooth_aim_y = pose_pos[4][31:0];
    r.smooth_aim_z = pose_pos[5][31:0];
    return r;
  endfunction

  // Send one item: random gap, then hold until the transfer.
  task automatic send_pose(sdpf_pkg::in_t it);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    pose_queue.push_back(follow_pose(it));
  endtask

  // Wait for every expected result, then let the block settle.
  task automatic drain;
    int n;
    n = 0;
    in_valid <= 1'b0;
    while (pose_queue.size() != 0 && n < DrainLimit) begin
      @(posedge clk);
      n++;
    end
    repeat (10) @(posedge clk);
  endtask

  // Only called with the block idle.
  task automatic write_reg(logic [sdpf_pkg::CfgIdxW-1:0] idx,
                           logic [sdpf_pkg::CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      sdpf_pkg::CFG_SPRING:   spring_gain   = val[15:0];
      sdpf_pkg::CFG_FRICTION: friction_gain = val[15:0];
      sdpf_pkg::CFG_REF_DIST: ref_dist      = val[30:0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 2047)) - 1024);
      3, 4: return $urandom;
      default: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
    endcase
  endfunction

  function automatic sdpf_pkg::in_t rand_pose(bit rs);
    sdpf_pkg::in_t it;
    it.eye_x = rand_coord(); it.eye_y = rand_coord(); it.eye_z = rand_coord();
    it.aim_x = rand_coord(); it.aim_y = rand_coord(); it.aim_z = rand_coord();
    it.restart = rs;
    return it;
  endfunction

  // Small move of a command, so the spring settles over a trajectory.
  function automatic logic [31:0] nudge(logic [31:0] c);
    return c + 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
  endfunction

  // Result side: random stall per transfer, check against the oldest entry.
  int stall_left = 0;
  always @(posedge clk) begin
    sdpf_pkg::out_t want;
    logic [191:0] w, g;
    if (out_valid && !out_stall) begin
      if (pose_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer %h", out_data);
      end else begin
        want = pose_queue.pop_front();
        w = want;
        g = out_data;
        for (int f = 0; f < 6; f++)
          if (w[191-32*f -: 32] !== g[191-32*f -: 32]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("field %0d: expected %h got %h", f, w[191-32*f -: 32],
                       g[191-32*f -: 32]);
          end
      end
      stall_left = quiet ? 0 : $urandom_range(0, 7);
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // First item snaps; then coordinate extremes, zero distance, a restart.
  task automatic test_directed;
    sdpf_pkg::in_t it;
    it = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF,
           32'hFFFF_FFFF, 1'b0};
    send_pose(it);
    it.restart = 1'b0;
    send_pose(it);
    it = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
           32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0};
    repeat (3) send_pose(it);
    // eye on the aim point: no spring term, damping still runs
    it = '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0001_0000,
           32'h0002_0000, 32'h0003_0000, 1'b0};
    repeat (3) send_pose(it);
    it.restart = 1'b1;
    send_pose(it);
    it = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1, 1'b0};
    repeat (3) send_pose(it);
    it = '{32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0};
    repeat (3) send_pose(it);
    repeat (6) send_pose(rand_pose($urandom_range(0, 1)));
    drain();
  endtask

  // One follow trajectory: restart, then small moves; some noise items.
  task automatic run_trajectory(int len);
    sdpf_pkg::in_t it;
    it = rand_pose(1'b1);
    send_pose(it);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_pose(rand_pose($urandom_range(0, 3) == 0));
      end else begin
        it.eye_x = nudge(it.eye_x); it.eye_y = nudge(it.eye_y);
        it.eye_z = nudge(it.eye_z); it.aim_x = nudge(it.aim_x);
        it.aim_y = nudge(it.aim_y); it.aim_z = nudge(it.aim_z);
        it.restart = 1'b0;
        send_pose(it);
      end
    end
  endtask

  // Gain settings including extremes, an ignored index and zero distance.
  task automatic test_config;
    logic [31:0] springs[5] = '{32'd0, 32'd65535, 32'd6554, 32'd1, 32'hFFFF_0123};
    logic [31:0] frics[5]   = '{32'd65535, 32'd0, 32'd6554, 32'd32768, 32'hFFFF_FFFF};
    logic [31:0] refs[5]    = '{32'd1, 32'h7FFF_FFFF, 32'd0, 32'd655360, 32'hFFFF_FFFF};
    for (int s = 0; s < 5; s++) begin
      write_reg(sdpf_pkg::CFG_SPRING, springs[s]);
      write_reg(sdpf_pkg::CFG_FRICTION, frics[s]);
      write_reg(sdpf_pkg::CFG_REF_DIST, refs[s]);
      write_reg(CfgUnused, $urandom);
      run_trajectory(30);
      drain();
    end
  endtask

  task automatic test_random;
    int sent;
    sent = 0;
    write_reg(sdpf_pkg::CFG_SPRING, 16'd6554);
    write_reg(sdpf_pkg::CFG_FRICTION, 16'd6554);
    write_reg(sdpf_pkg::CFG_REF_DIST, 31'd655360);
    while (sent < 1600) begin
      int len;
      len = $urandom_range(5, 60);
      quiet = ($urandom_range(0, 5) == 0);
      run_trajectory(len);
      sent += len + 1;
      if ($urandom_range(0, 9) == 0) begin
        drain();
        write_reg(sdpf_pkg::CFG_SPRING, $urandom);
        write_reg(sdpf_pkg::CFG_FRICTION, $urandom);
        write_reg(sdpf_pkg::CFG_REF_DIST, $urandom_range(1, 32'h7FFF_FFFF));
      end
    end
    quiet = 1'b0;
    drain();
  endtask

  initial begin
    spring_gain   = 6554;
    friction_gain = 6554;
    ref_dist      = 655360;
    snap_pending  = 1'b1;
    for (int a = 0; a < 6; a++) begin
      pose_pos[a] = 0;
      pose_vel[a] = 0;
    end
    // falling edge after time zero so the asynchronous reset fires
    rst_n <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config();
    test_random();
    repeat (120) @(posedge clk);
    if (mismatches == 0 && pose_queue.size() == 0) begin
      $display("spring_damper_pose_follower: match");
    end else begin
      $display("spring_damper_pose_follower: mismatch");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #20000000;
    $display("spring_damper_pose_follower: mismatch");
    $finish;
  end

endmodule

`default_nettype wire

### files.f
hw/rtl/sdpf_pkg.sv
hw/rtl/sdpf_ctrl.sv
hw/rtl/sdpf_datapath.sv
hw/rtl/spring_damper_pose_follower.sv
bench/tb.sv
